>>> hdl/bgcd_pkg.sv
// Shared constants, command codes and control structs for the binary GCD core.
package bgcd_pkg;

  localparam int WIDTH  = 32;               // operand width used by the cell row
  localparam int DATA_W = 32;               // width of each stream field
  localparam int TWOS_W = $clog2(WIDTH);    // holds a shared power of two, 0..WIDTH-1

  // Cell commands, broadcast to every cell of the row
  localparam logic [2:0] OP_HOLD   = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_SHR_AB = 3'd2;
  localparam logic [2:0] OP_SHR_A  = 3'd3;
  localparam logic [2:0] OP_SHR_B  = 3'd4;
  localparam logic [2:0] OP_SUB    = 3'd5;
  localparam logic [2:0] OP_SHL_A  = 3'd6;
  localparam logic [2:0] OP_COPY_B = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic       swap;   // with OP_SUB: a <= b, b <= a - b
  } cell_cmd_t;

  typedef struct packed {
    logic a_lsb;
    logic b_lsb;
    logic a_zero;
    logic b_zero;
    logic a_gt_b;       // borrow out of b - a
  } row_status_t;

endpackage

>>> hdl/bgcd_cell.sv
// One bit slice of the operand row: holds bit i of a and b.
module bgcd_cell
  import bgcd_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      ld_a,
  input  logic      ld_b,
  input  logic      a_hi,     // a bit of the next higher cell
  input  logic      b_hi,
  input  logic      a_lo,     // a bit of the next lower cell
  input  logic      bba_in,   // borrow of b - a from lower cell
  input  logic      bab_in,   // borrow of a - b from lower cell
  output logic      a_q,
  output logic      b_q,
  output logic      bba_out,
  output logic      bab_out
);

  logic a_r, a_nxt;
  logic b_r, b_nxt;
  logic d_ba, d_ab;

  assign d_ba    = b_r ^ a_r ^ bba_in;
  assign bba_out = (~b_r & a_r) | (~(b_r ^ a_r) & bba_in);
  assign d_ab    = a_r ^ b_r ^ bab_in;
  assign bab_out = (~a_r & b_r) | (~(a_r ^ b_r) & bab_in);

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    unique case (cmd.op)
      OP_HOLD: begin
      end
      OP_LOAD: begin
        a_nxt = ld_a;
        b_nxt = ld_b;
      end
      OP_SHR_AB: begin
        a_nxt = a_hi;
        b_nxt = b_hi;
      end
      OP_SHR_A: a_nxt = a_hi;
      OP_SHR_B: b_nxt = b_hi;
      OP_SUB: begin
        if (cmd.swap) begin
          a_nxt = b_r;
          b_nxt = d_ab;
        end else begin
          b_nxt = d_ba;
        end
      end
      OP_SHL_A:  a_nxt = a_lo;
      OP_COPY_B: a_nxt = b_r;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign a_q = a_r;
  assign b_q = b_r;

endmodule

>>> hdl/bgcd_ctrl.sv
// Sequencer: steps the cell row through the Stein reduction and owns the handshakes.
module bgcd_ctrl
  import bgcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  row_status_t st,
  output cell_cmd_t   cmd,
  output logic        out_load
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_TWOS = 3'd2;
  localparam logic [2:0] S_ODDA = 3'd3;
  localparam logic [2:0] S_LOOP = 3'd4;
  localparam logic [2:0] S_SHL  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [TWOS_W-1:0] twos_r, twos_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic              out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_free   = ~ovalid_r | out_tready;

  always_comb begin
    state_nxt  = state_r;
    twos_nxt   = twos_r;
    ovalid_nxt = ovalid_r & ~out_tready;
    cmd.op     = OP_HOLD;
    cmd.swap   = st.a_gt_b;
    out_load   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          twos_nxt  = '0;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        priority if (st.a_zero) begin
          cmd.op    = OP_COPY_B;
          state_nxt = S_DONE;
        end else if (st.b_zero) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_TWOS;
        end
      end
      S_TWOS: begin
        if (!st.a_lsb && !st.b_lsb) begin
          cmd.op   = OP_SHR_AB;
          twos_nxt = twos_r + 1'b1;
        end else begin
          state_nxt = S_ODDA;
        end
      end
      S_ODDA: begin
        if (!st.a_lsb) cmd.op = OP_SHR_A;
        else           state_nxt = S_LOOP;
      end
      S_LOOP: begin
        priority if (st.b_zero) begin
          state_nxt = S_SHL;
        end else if (!st.b_lsb) begin
          cmd.op = OP_SHR_B;
        end else begin
          cmd.op = OP_SUB;
        end
      end
      S_SHL: begin
        if (twos_r != '0) begin
          cmd.op   = OP_SHL_A;
          twos_nxt = twos_r - 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      twos_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      twos_r   <= twos_nxt;
    end
  end

endmodule

>>> hdl/binary_gcd_core.sv
// Top level of the binary (Stein) GCD core: cell row, sequencer and result register.
//
// Takes one word of two unsigned operands and returns one word holding their
// greatest common divisor; a zero operand yields the other operand, so
// gcd(0,0) = 0. The operands sit in a row of WIDTH one-bit cells that shift
// right, shift left or subtract together under one command per cycle; a
// sequencer strips the shared factors of two, makes a odd, then alternates
// shifting b and ordered subtraction until b is zero, and shifts the shared
// twos back in. One pair at a time is in flight. Latency is data dependent.
// A zero operand skips the reduction; otherwise each shift, each subtraction
// and each restored factor of two takes its own command. A result that
// finds the output register still full waits until that register is free.
// The critical path is the WIDTH-bit borrow ripple through the cells. A
// finished result waits in an output register, so the next pair is
// accepted while the previous result is still waiting to be taken.
module binary_gcd_core
  import bgcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [2*DATA_W-1:0] in_tdata,   // [31:0] operand_a, [63:32] operand_b
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [DATA_W-1:0]   out_tdata   // [31:0] divisor
);

  logic [WIDTH-1:0]  a_vec, b_vec;
  logic [WIDTH-1:0]  ld_a, ld_b;
  logic [WIDTH:0]    bba, bab;       // borrow chains for b - a and a - b
  logic [DATA_W-1:0] result_word;
  logic [DATA_W-1:0] divisor_r;
  cell_cmd_t         cmd;
  row_status_t       st;
  logic              out_load;

  assign bba[0] = 1'b0;
  assign bab[0] = 1'b0;

  // operand bits beyond the field width load as zero
  genvar gi;
  generate
    for (gi = 0; gi < WIDTH; gi++) begin : g_ld
      if (gi < DATA_W) begin : g_in
        assign ld_a[gi] = in_tdata[gi];
        assign ld_b[gi] = in_tdata[DATA_W + gi];
      end else begin : g_pad
        assign ld_a[gi] = 1'b0;
        assign ld_b[gi] = 1'b0;
      end
    end
  endgenerate

  // the cell row; ends of the shift chains see zero
  generate
    for (gi = 0; gi < WIDTH; gi++) begin : g_cell
      logic a_hi, b_hi, a_lo;
      if (gi == WIDTH - 1) begin : g_top
        assign a_hi = 1'b0;
        assign b_hi = 1'b0;
      end else begin : g_mid
        assign a_hi = a_vec[gi+1];
        assign b_hi = b_vec[gi+1];
      end
      if (gi == 0) begin : g_bot
        assign a_lo = 1'b0;
      end else begin : g_up
        assign a_lo = a_vec[gi-1];
      end
      bgcd_cell u_cell (
        .clk     (clk),
        .cmd     (cmd),
        .ld_a    (ld_a[gi]),
        .ld_b    (ld_b[gi]),
        .a_hi    (a_hi),
        .b_hi    (b_hi),
        .a_lo    (a_lo),
        .bba_in  (bba[gi]),
        .bab_in  (bab[gi]),
        .a_q     (a_vec[gi]),
        .b_q     (b_vec[gi]),
        .bba_out (bba[gi+1]),
        .bab_out (bab[gi+1])
      );
    end
  endgenerate

  // row flags for the sequencer
  assign st.a_lsb  = a_vec[0];
  assign st.b_lsb  = b_vec[0];
  assign st.a_zero = ~|a_vec;
  assign st.b_zero = ~|b_vec;
  assign st.a_gt_b = bba[WIDTH];

  bgcd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd),
    .out_load   (out_load)
  );

  // result always ends up in a
  generate
    for (gi = 0; gi < DATA_W; gi++) begin : g_res
      if (gi < WIDTH) begin : g_bit
        assign result_word[gi] = a_vec[gi];
      end else begin : g_zero
        assign result_word[gi] = 1'b0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (out_load) divisor_r <= result_word;
  end

  assign out_tdata = divisor_r;

endmodule

>>> hdl/bgcd_checker.sv
// Port-level checker for the binary GCD core, bound to the top level.
module bgcd_checker
  import bgcd_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [DATA_W-1:0]   out_tdata
);

  logic in_acc;
  assign in_acc = in_tvalid & in_tready;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed or dropped while stalled");

  // one pair at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input accepted while a pair is in work");

  // no result can appear before the sequencer has passed its check and done states
  a_min_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !$rose(out_tvalid) ##1 !$rose(out_tvalid))
    else $error("result appeared too early");

  // reset empties the result register
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind binary_gcd_core bgcd_checker u_bgcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> bench/binary_gcd_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the binary GCD core: directed and random operand words.
module binary_gcd_core_test;
  import bgcd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 4 * WIDTH + 16;   // worst-case latency plus margin
  localparam int HOLD_CYCLES  = 400;              // long receiver hold-off

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] divisor;
  } gcd_case_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [2*DATA_W-1:0] in_tdata   = '0;   // [31:0] operand_a, [63:32] operand_b
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [DATA_W-1:0]   out_tdata;         // [31:0] divisor

  gcd_case_t   divisors_due[$];   // accepted pairs whose divisor has not come back yet
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          steady      = 1'b0;   // no idling on either side while set
  bit          hold_req    = 1'b0;
  int          hold_left   = 0;

  binary_gcd_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stein's method on 32-bit operands; a zero operand yields the other one.
  function automatic logic [31:0] stein_gcd(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] u;
    logic [31:0] v;
    logic [31:0] t;
    int          twos;
    u    = x;
    v    = y;
    twos = 0;
    if (u == 32'd0) return v;
    if (v == 32'd0) return u;
    while (!u[0] && !v[0]) begin
      u = u >> 1;
      v = v >> 1;
      twos++;
    end
    while (!u[0]) u = u >> 1;
    do begin
      while (!v[0]) v = v >> 1;
      if (u > v) begin
        t = u;
        u = v;
        v = t;
      end
      v = v - u;
    end while (v != 32'd0);
    return u << twos;
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin : drive_ready
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin : check_divisor
    gcd_case_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (divisors_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: divisor %h", out_tdata);
      end else begin
        want = divisors_due.pop_front();
        if (out_tdata !== want.divisor) begin
          mismatches++;
          if (mismatches <= 10)
            $display("gcd(%h, %h): divisor expected %h, got %h",
                     want.a, want.b, want.divisor, out_tdata);
        end
      end
    end
  end

  // Offers one operand word and records its divisor once accepted.
  task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
    gcd_case_t item;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    do @(posedge clk); while (!in_tready);
    item.a       = a;
    item.b       = b;
    item.divisor = stein_gcd(a, b);
    divisors_due = {divisors_due, item};
  endtask

  // Sender goes quiet until every divisor owed has come back.
  task automatic wait_results;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (divisors_due.size() != 0) @(posedge clk);
  endtask

  // Mixes random, common-factor, shifted, small, equal-or-zero and power-of-two pairs, either way round.
  task automatic pick_pair(output logic [31:0] a, output logic [31:0] b);
    logic [31:0] g;
    logic [31:0] t;
    int          gs;
    int          ts;
    case ($urandom_range(9))
      0, 1, 2: begin
        a = $urandom;
        b = $urandom;
      end
      3, 4, 5: begin
        gs = $urandom_range(24, 1);
        ts = $urandom_range(6);
        g  = ($urandom >> (32 - gs)) | 32'd1;
        a  = (g * ($urandom >> gs)) << ts;
        b  = (g * ($urandom >> gs)) << ts;
      end
      6: begin
        a = $urandom << $urandom_range(31);
        b = $urandom << $urandom_range(31);
      end
      7: begin
        a = $urandom_range(15);
        b = $urandom_range(15);
      end
      8: begin
        a = $urandom;
        b = $urandom_range(1) ? a : 32'd0;
      end
      default: begin
        a = 32'd1 << $urandom_range(31);
        b = $urandom;
      end
    endcase
    if ($urandom_range(1)) begin
      t = a;
      a = b;
      b = t;
    end
  endtask

  task automatic test_zero_operands;
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h0000_0001);
    send_pair(32'h0000_0001, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h8000_0000);
    send_pair(32'h1234_5678, 32'h0000_0000);
  endtask

  task automatic test_extremes;
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h0000_0001, 32'h0000_0001);
    send_pair(32'h0000_0001, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_pair(32'h8000_0000, 32'h8000_0000);   // 31 shared twos to restore
    send_pair(32'h8000_0000, 32'hC000_0000);
    send_pair(32'h8000_0000, 32'h0000_0001);
    send_pair(32'hFFFF_FFFE, 32'h8000_0000);
    send_pair(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFB, 32'hFFFF_FFF1);
    send_pair(32'hF000_0000, 32'h0F00_0000);
    send_pair(32'h0000_0006, 32'h0000_0004);
    send_pair(32'h0000_0012, 32'h0000_0030);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555);
    send_pair(32'h0000_0001, 32'h8000_0000);
    send_pair(32'hFFFF_0000, 32'h0000_FFFF);
  endtask

  // Receiver holds off while the sender keeps offering words.
  task automatic test_output_backpressure;
    logic [31:0] a;
    logic [31:0] b;
    hold_req = 1'b1;
    repeat (30) begin
      pick_pair(a, b);
      send_pair(a, b);
    end
    wait_results;
  endtask

  task automatic test_random_pairs(input int count);
    logic [31:0] a;
    logic [31:0] b;
    repeat (count) begin
      pick_pair(a, b);
      send_pair(a, b);
    end
  endtask

  task automatic test_steady_stream(input int count);
    steady = 1'b1;
    test_random_pairs(count);
    steady = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_zero_operands;
    test_extremes;
    wait_results;
    test_output_backpressure;
    test_random_pairs(700);
    wait_results;
    test_steady_stream(300);
    test_random_pairs(300);

    wait_results;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && divisors_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
